// ===== hw/rtl/ffgtg_pkg.sv =====
// ffgtg_pkg: widths, fixed-point constants and the cordic arctangent table
// shared by the formation follower go-to-goal controller and its units
// no dependencies
`default_nettype none

package ffgtg_pkg;

    // field widths
    localparam int POS_W   = 16;   // q8.8 position
    localparam int HEAD_W  = 15;   // q.12 yaw
    localparam int CFG_W   = 13;   // config register width
    localparam int SPEED_W = 12;   // q.12 speed
    localparam int RATE_W  = 16;   // q.12 turn rate

    // datapath widths
    localparam int DIFF_W  = 18;            // goal minus own position
    localparam int PROD_W  = 2 * DIFF_W;    // shared multiplier product
    localparam int ROOT_W  = 18;            // distance, floor sqrt
    localparam int RAD_W   = 2 * ROOT_W;    // radicand
    localparam int REM_W   = ROOT_W + 2;    // square root remainder
    localparam int CRD_W   = 32;            // cordic x/y
    localparam int CRD_SH  = 12;            // input scaling of cordic x/y
    localparam int Z_W     = 20;            // q.16 angle accumulator
    localparam int ATAN_W  = 16;
    localparam int ATAN_IDX_W = 5;

    // fixed-point constants
    localparam logic signed [Z_W-1:0]      PI_Q16     = 20'sd205887;
    localparam logic signed [HEAD_W-1:0]   PI_Q12     = 15'sd12868;
    localparam logic signed [RATE_W-1:0]   WRAP_LIMIT = -16'sd12861;
    localparam logic signed [DIFF_W-1:0]   WRAP_ADD   = 18'sd25723;
    localparam logic signed [DIFF_W-1:0]   WRAP_GAIN  = 18'sd819;
    localparam logic signed [POS_W-1:0]    DEF_OFFSET_X = -16'sd512;
    localparam logic [SPEED_W-1:0] SPEED_FAST = 12'd1638;
    localparam logic [SPEED_W-1:0] SPEED_MID  = 12'd1229;
    localparam logic [SPEED_W-1:0] SPEED_SLOW = 12'd819;

    // atan(2^-i) in q.16
    function automatic logic [ATAN_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        unique case (idx)
            5'd0:    v = 16'd51472;
            5'd1:    v = 16'd30385;
            5'd2:    v = 16'd16055;
            5'd3:    v = 16'd8150;
            5'd4:    v = 16'd4091;
            5'd5:    v = 16'd2047;
            5'd6:    v = 16'd1024;
            5'd7:    v = 16'd512;
            5'd8:    v = 16'd256;
            5'd9:    v = 16'd128;
            5'd10:   v = 16'd64;
            5'd11:   v = 16'd32;
            5'd12:   v = 16'd16;
            5'd13:   v = 16'd8;
            5'd14:   v = 16'd4;
            5'd15:   v = 16'd2;
            5'd16:   v = 16'd1;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ffgtg_isqrt.sv =====
// ffgtg_isqrt: floor integer square root, one result bit per cycle
// depends on ffgtg_pkg
`default_nettype none

module ffgtg_isqrt (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [ffgtg_pkg::RAD_W-1:0]   i_radicand,
    output logic                               o_busy,
    output logic [ffgtg_pkg::ROOT_W-1:0]       o_root
);

    localparam int CNT_W = $clog2(ffgtg_pkg::ROOT_W + 1);

    logic [CNT_W-1:0]                r_cnt;
    logic [ffgtg_pkg::RAD_W-1:0]     r_rad;
    logic [ffgtg_pkg::REM_W-1:0]     r_rem;
    logic [ffgtg_pkg::ROOT_W-1:0]    r_root;

    logic [ffgtg_pkg::REM_W+1:0]     w_rem_sh;
    logic [ffgtg_pkg::REM_W+1:0]     w_trial;
    logic                            w_fit;

    assign w_rem_sh = {r_rem, r_rad[ffgtg_pkg::RAD_W-1 -: 2]};
    assign w_trial  = {2'b00, r_root, 2'b01};
    assign w_fit    = (w_rem_sh >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= CNT_W'(ffgtg_pkg::ROOT_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // one digit pair per cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_cnt != '0) begin
            r_rad <= {r_rad[ffgtg_pkg::RAD_W-3:0], 2'b00};
            if (w_fit) begin
                r_rem  <= ffgtg_pkg::REM_W'(w_rem_sh - w_trial);
                r_root <= {r_root[ffgtg_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= ffgtg_pkg::REM_W'(w_rem_sh);
                r_root <= {r_root[ffgtg_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_root = r_root;

endmodule

`default_nettype wire

// ===== hw/rtl/ffgtg_cordic.sv =====
// ffgtg_cordic: vectoring cordic atan2, one micro-rotation per cycle
// plus a rounding step; depends on ffgtg_pkg
`default_nettype none

module ffgtg_cordic #(
    parameter int STEPS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic signed [ffgtg_pkg::DIFF_W-1:0] i_dx,
    input  wire logic signed [ffgtg_pkg::DIFF_W-1:0] i_dy,
    output logic                                     o_busy,
    output logic signed [ffgtg_pkg::HEAD_W-1:0]      o_angle
);

    localparam int IW = $clog2(STEPS);

    logic                                   r_busy;
    logic                                   r_round;
    logic                                   r_zero;
    logic [IW-1:0]                          r_i;
    logic signed [ffgtg_pkg::CRD_W-1:0]     r_x;
    logic signed [ffgtg_pkg::CRD_W-1:0]     r_y;
    logic signed [ffgtg_pkg::Z_W-1:0]       r_z;
    logic signed [ffgtg_pkg::HEAD_W-1:0]    r_angle;

    logic signed [ffgtg_pkg::CRD_W-1:0]     w_x0;
    logic signed [ffgtg_pkg::CRD_W-1:0]     w_y0;
    logic signed [ffgtg_pkg::CRD_W-1:0]     w_xs;
    logic signed [ffgtg_pkg::CRD_W-1:0]     w_ys;
    logic signed [ffgtg_pkg::Z_W-1:0]       w_atan;
    logic signed [ffgtg_pkg::Z_W-1:0]       w_zr;

    assign w_x0   = ffgtg_pkg::CRD_W'(i_dx) <<< ffgtg_pkg::CRD_SH;
    assign w_y0   = ffgtg_pkg::CRD_W'(i_dy) <<< ffgtg_pkg::CRD_SH;
    assign w_xs   = r_x >>> r_i;
    assign w_ys   = r_y >>> r_i;
    assign w_atan = ffgtg_pkg::Z_W'(ffgtg_pkg::atan_q16(ffgtg_pkg::ATAN_IDX_W'(r_i)));
    assign w_zr   = (r_z + ffgtg_pkg::Z_W'(8)) >>> 4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_round <= 1'b0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_round <= 1'b0;
        end else if (r_busy && r_round) begin
            r_busy  <= 1'b0;
            r_round <= 1'b0;
        end else if (r_busy && r_i == IW'(STEPS - 1)) begin
            r_round <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_i    <= '0;
            r_zero <= (i_dx == '0) && (i_dy == '0);
            // left half plane: pre-rotate by pi
            if (i_dx < 0) begin
                r_x <= -w_x0;
                r_y <= -w_y0;
                r_z <= (i_dy >= 0) ? ffgtg_pkg::PI_Q16 : -ffgtg_pkg::PI_Q16;
            end else begin
                r_x <= w_x0;
                r_y <= w_y0;
                r_z <= '0;
            end
        end else if (r_busy && !r_round) begin
            r_i <= r_i + 1'b1;
            if (r_y >= 0) begin
                r_x <= r_x + w_ys;
                r_y <= r_y - w_xs;
                r_z <= r_z + w_atan;
            end else begin
                r_x <= r_x - w_ys;
                r_y <= r_y + w_xs;
                r_z <= r_z - w_atan;
            end
        end else if (r_busy && r_round) begin
            if (r_zero) begin
                r_angle <= '0;
            end else if (w_zr > ffgtg_pkg::Z_W'(ffgtg_pkg::PI_Q12)) begin
                r_angle <= ffgtg_pkg::PI_Q12;
            end else if (w_zr < -ffgtg_pkg::Z_W'(ffgtg_pkg::PI_Q12)) begin
                r_angle <= -ffgtg_pkg::PI_Q12;
            end else begin
                r_angle <= ffgtg_pkg::HEAD_W'(w_zr);
            end
        end
    end

    assign o_busy  = r_busy;
    assign o_angle = r_angle;

endmodule

`default_nettype wire

// ===== hw/rtl/formation_follower_go_to_goal.sv =====
// formation_follower_go_to_goal: follower formation controller, top level
// sequencer, pose state, shared multiplier; uses ffgtg_pkg, ffgtg_isqrt, ffgtg_cordic
//
//   channel   dir  handshake                      payload
//   s_axis    in   i_s_axis_tvalid/o_..._tready   tdata pos_x,pos_y,heading; tuser op
//   m_axis    out  o_m_axis_tvalid/i_..._tready   tdata linear_speed,angular_rate
//   cfg       in   i_cfg_valid/o_cfg_ready        i_cfg_index, i_cfg_data
//
// odometry and offset beats only update the pose or offset registers; a leader pose
// beat runs the difference, squaring, start, run, gain and finish steps, the run step
// waiting on the 18 digit steps of the square root unit and the cordic unit beside it
// i_rst_n is synchronous, active low; it restores config defaults and clears poses
// a finished command waits in the output register; the next odometry or offset
// beat is still taken, a new leader pose stalls only until that register frees
`default_nettype none

module formation_follower_go_to_goal #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave stream
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [47:0] i_s_axis_tdata,   // pos_x[15:0], pos_y[31:16], heading[46:32]
    input  wire logic [1:0]  i_s_axis_tuser,   // op[1:0]
    // master stream
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,   // linear_speed[11:0], angular_rate[27:12]
    // config write
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [12:0] i_cfg_data
);

    // op codes
    localparam logic [1:0] OP_LEADER = 2'd0;
    localparam logic [1:0] OP_ODOM   = 2'd1;
    localparam logic [1:0] OP_OFFSET = 2'd2;

    // config register indexes
    localparam logic [2:0] CFG_FAR   = 3'd0;
    localparam logic [2:0] CFG_NEAR  = 3'd1;
    localparam logic [2:0] CFG_STOP  = 3'd2;
    localparam logic [2:0] CFG_TOL   = 3'd3;
    localparam logic [2:0] CFG_ALIGN = 3'd4;

    localparam int PW = ffgtg_pkg::POS_W;
    localparam int HW = ffgtg_pkg::HEAD_W;
    localparam int DW = ffgtg_pkg::DIFF_W;
    localparam int CW = ffgtg_pkg::CFG_W;
    localparam int RW = ffgtg_pkg::RATE_W;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_DIFF   = 8'b0000_0010,
        ST_SQX    = 8'b0000_0100,
        ST_SQY    = 8'b0000_1000,
        ST_START  = 8'b0001_0000,
        ST_RUN    = 8'b0010_0000,
        ST_GAIN   = 8'b0100_0000,
        ST_FINISH = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [CW-1:0] r_far, r_near, r_stop, r_tol, r_align;

    // pose and offset state
    logic signed [PW-1:0] r_leader_x, r_leader_y, r_own_x, r_own_y;
    logic signed [PW-1:0] r_offset_x, r_offset_y;
    logic signed [HW-1:0] r_leader_hd, r_own_hd;

    // datapath
    logic signed [DW-1:0]                    r_dx, r_dy;
    logic [ffgtg_pkg::PROD_W-1:0]            r_acc;
    logic signed [RW-1:0]                    r_err;
    logic signed [DW-1:0]                    r_ea;

    // output register
    logic                                    r_out_valid;
    logic [ffgtg_pkg::SPEED_W-1:0]           r_out_speed;
    logic signed [RW-1:0]                    r_out_rate;

    // input fields
    logic signed [PW-1:0] w_px, w_py;
    logic signed [HW-1:0] w_hd;
    logic [1:0]           w_op;
    logic                 w_s_fire;
    logic                 w_cfg_fire;

    assign w_px = i_s_axis_tdata[15:0];
    assign w_py = i_s_axis_tdata[31:16];
    assign w_hd = i_s_axis_tdata[46:32];
    assign w_op = i_s_axis_tuser;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_s_fire        = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready     = 1'b1;
    assign w_cfg_fire      = i_cfg_valid && o_cfg_ready;

    // iterative units
    logic                               w_sq_busy, w_cd_busy, w_start;
    logic [ffgtg_pkg::ROOT_W-1:0]       w_dist;
    logic signed [HW-1:0]               w_bearing;

    assign w_start = (r_state == ST_START);

    ffgtg_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_radicand (r_acc),
        .o_busy     (w_sq_busy),
        .o_root     (w_dist)
    );

    ffgtg_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_dx    (r_dx),
        .i_dy    (r_dy),
        .o_busy  (w_cd_busy),
        .o_angle (w_bearing)
    );

    // shared multiplier: squares of dx and dy, then the 0.2 wrap gain
    logic signed [DW-1:0]                w_mul_a, w_mul_b;
    logic signed [ffgtg_pkg::PROD_W-1:0] w_prod;

    always_comb begin
        unique case (r_state)
            ST_SQX: begin
                w_mul_a = r_dx;
                w_mul_b = r_dx;
            end
            ST_SQY: begin
                w_mul_a = r_dy;
                w_mul_b = r_dy;
            end
            default: begin
                w_mul_a = r_ea;
                w_mul_b = ffgtg_pkg::WRAP_GAIN;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // heading error, held for the finish step
    logic signed [RW-1:0] w_err;
    assign w_err = RW'(w_bearing) - RW'(r_own_hd);

    // offset y for an offset beat: doubled when x offset is zero, saturated
    logic signed [PW-1:0] w_off_y;
    always_comb begin
        if (w_px != '0) begin
            w_off_y = w_py;
        end else if (w_py[PW-1:PW-2] == 2'b01) begin
            w_off_y = {1'b0, {(PW-1){1'b1}}};
        end else if (w_py[PW-1:PW-2] == 2'b10) begin
            w_off_y = {1'b1, {(PW-1){1'b0}}};
        end else begin
            w_off_y = {w_py[PW-2:0], 1'b0};
        end
    end

    // command formation
    logic [ffgtg_pkg::SPEED_W-1:0] w_speed;
    logic signed [RW-1:0]          w_rate;
    logic signed [ffgtg_pkg::PROD_W-1:0] w_wrapped;
    logic signed [HW+1:0]          w_lead_minus_own;
    logic [ffgtg_pkg::ROOT_W-1:0]  w_far_x, w_near_x, w_stop_x;

    assign w_far_x   = ffgtg_pkg::ROOT_W'(r_far);
    assign w_near_x  = ffgtg_pkg::ROOT_W'(r_near);
    assign w_stop_x  = ffgtg_pkg::ROOT_W'(r_stop);
    assign w_wrapped = ($signed(r_acc) + ffgtg_pkg::PROD_W'(2048)) >>> 12;
    assign w_lead_minus_own = (HW+2)'(r_leader_hd) - (HW+2)'(r_own_hd);

    always_comb begin
        if (w_dist > w_stop_x) begin
            // driving: speed by band, turn rate from heading error
            if (w_dist > w_far_x) begin
                w_speed = ffgtg_pkg::SPEED_FAST;
            end else if (w_dist < w_far_x && w_dist > w_near_x) begin
                w_speed = ffgtg_pkg::SPEED_MID;
            end else begin
                w_speed = ffgtg_pkg::SPEED_SLOW;
            end
            if (r_err < ffgtg_pkg::WRAP_LIMIT) begin
                w_rate = RW'(w_wrapped);
            end else begin
                w_rate = r_err;
            end
        end else begin
            // inside stop radius: align with leader yaw only, and only for a non-negative leader yaw
            w_speed = '0;
            if (!r_leader_hd[HW-1] && w_lead_minus_own > $signed((HW+2)'(r_tol))) begin
                w_rate = RW'(r_align);
            end else if (!r_leader_hd[HW-1]
                         && -w_lead_minus_own > $signed((HW+2)'(r_tol))) begin
                w_rate = -RW'(r_align);
            end else begin
                w_rate = '0;
            end
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_s_fire && w_op == OP_LEADER) begin
                    n_state = ST_DIFF;
                end
            end
            ST_DIFF:  n_state = ST_SQX;
            ST_SQX:   n_state = ST_SQY;
            ST_SQY:   n_state = ST_START;
            ST_START: n_state = ST_RUN;
            ST_RUN: begin
                if (!w_sq_busy && !w_cd_busy) begin
                    n_state = ST_GAIN;
                end
            end
            ST_GAIN:  n_state = ST_FINISH;
            ST_FINISH: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_far   <= 13'd384;
            r_near  <= 13'd128;
            r_stop  <= 13'd51;
            r_tol   <= 13'd410;
            r_align <= 13'd2048;
        end else if (w_cfg_fire) begin
            unique case (i_cfg_index)
                CFG_FAR:   r_far   <= i_cfg_data;
                CFG_NEAR:  r_near  <= i_cfg_data;
                CFG_STOP:  r_stop  <= i_cfg_data;
                CFG_TOL:   r_tol   <= i_cfg_data;
                CFG_ALIGN: r_align <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pose and offset state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_leader_x  <= '0;
            r_leader_y  <= '0;
            r_leader_hd <= '0;
            r_own_x     <= '0;
            r_own_y     <= '0;
            r_own_hd    <= '0;
            r_offset_x  <= '0;
            r_offset_y  <= '0;
        end else if (w_s_fire) begin
            unique case (w_op)
                OP_LEADER: begin
                    r_leader_x  <= w_px;
                    r_leader_y  <= w_py;
                    r_leader_hd <= w_hd;
                    // unset formation falls back to an x offset of minus two metres
                    if (r_offset_x == '0 && r_offset_y == '0) begin
                        r_offset_x <= ffgtg_pkg::DEF_OFFSET_X;
                    end
                end
                OP_ODOM: begin
                    r_own_x  <= w_px;
                    r_own_y  <= w_py;
                    r_own_hd <= w_hd;
                end
                OP_OFFSET: begin
                    r_offset_x <= w_px;
                    r_offset_y <= w_off_y;
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_DIFF: begin
                // goal = (leader_x - offset_x, leader_y + offset_y)
                r_dx <= DW'(r_leader_x) - DW'(r_offset_x) - DW'(r_own_x);
                r_dy <= DW'(r_leader_y) + DW'(r_offset_y) - DW'(r_own_y);
            end
            ST_SQX:  r_acc <= w_prod;
            ST_SQY:  r_acc <= r_acc + w_prod;
            ST_RUN: begin
                r_err <= w_err;
                r_ea  <= DW'(w_err) + ffgtg_pkg::WRAP_ADD;
            end
            ST_GAIN: r_acc <= w_prod;
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_FINISH && (!r_out_valid || i_m_axis_tready)) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FINISH && (!r_out_valid || i_m_axis_tready)) begin
            r_out_speed <= w_speed;
            r_out_rate  <= w_rate;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {4'b0000, r_out_rate, r_out_speed};

    // checks
    a_leader_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_fire && w_op == OP_LEADER) |=> (r_state == ST_DIFF))
        else $error("leader pose did not start the command sequence");

    a_offset_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIFF) |-> !(r_offset_x == '0 && r_offset_y == '0))
        else $error("goal formed with an all-zero offset");

    a_units_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_START) |=> (w_sq_busy && w_cd_busy))
        else $error("iterative units not busy after start");

    a_speed_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_out_speed == '0 || r_out_speed == ffgtg_pkg::SPEED_FAST
            || r_out_speed == ffgtg_pkg::SPEED_MID || r_out_speed == ffgtg_pkg::SPEED_SLOW))
        else $error("linear speed outside the band set");

    a_out_from_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_FINISH))
        else $error("command loaded outside the finish step");

endmodule

`default_nettype wire
